// File: design/assert_macros.svh
// assertion macros used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/s2a_pkg.sv
// constants, key tables and decode types for the scancode decoder
`default_nettype none

package s2a_pkg;

   localparam int TABLE_ENTRIES = 58;
   localparam int MAP_KEYS      = 58;

   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam logic [6:0] KEY_MASK    = 7'h7F;
   localparam logic [6:0] SC_LSHIFT   = 7'h2A;
   localparam logic [6:0] SC_RSHIFT   = 7'h36;
   localparam logic [6:0] SC_CAPS     = 7'h3A;
   localparam logic [6:0] CASE_DELTA  = 7'd32;

   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;

   typedef logic [6:0] char_type;

   localparam char_type PLAIN_MAP [0:MAP_KEYS-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20
   };

   localparam char_type SHIFTED_MAP [0:MAP_KEYS-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20
   };

   // outcome of one scancode against the current flags
   typedef struct packed {
      logic     has_char;
      char_type ch;
      logic     shift_next;
      logic     caps_next;
   } decode_type;

endpackage

`default_nettype wire

// File: design/s2a_keymap.sv
// scancode classification, table lookup and case folding
`default_nettype none

module s2a_keymap import s2a_pkg::*; (
   input  wire logic [7:0] scancode,
   input  wire logic       shift_held,
   input  wire logic       caps_on,
   output decode_type      decode
);

   logic [6:0] key;
   logic       is_release;
   logic       is_shift;
   logic       in_table;
   char_type   raw_ch;
   char_type   folded_ch;

   assign key        = scancode[6:0] & KEY_MASK;
   assign is_release = (scancode & RELEASE_BIT) != 8'h00;
   assign is_shift   = (key == SC_LSHIFT) || (key == SC_RSHIFT);
   // keys past the end of the tables read as empty
   assign in_table   = ({1'b0, key} < 8'(TABLE_ENTRIES)) && ({1'b0, key} < 8'(MAP_KEYS));

   always_comb begin
      raw_ch = '0;
      if (in_table) begin
         raw_ch = shift_held ? SHIFTED_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
      end
   end

   always_comb begin
      folded_ch = raw_ch;
      if (caps_on != shift_held) begin
         if (raw_ch >= CHAR_LOWER_A && raw_ch <= CHAR_LOWER_Z) begin
            folded_ch = raw_ch - CASE_DELTA;
         end
      end else begin
         if (raw_ch >= CHAR_UPPER_A && raw_ch <= CHAR_UPPER_Z) begin
            folded_ch = raw_ch + CASE_DELTA;
         end
      end
   end

   always_comb begin
      decode.has_char   = 1'b0;
      decode.ch         = folded_ch;
      decode.shift_next = shift_held;
      decode.caps_next  = caps_on;
      priority if (is_release) begin
         if (is_shift) begin
            decode.shift_next = 1'b0;
         end
      end else if (is_shift) begin
         decode.shift_next = 1'b1;
      end else if (key == SC_CAPS) begin
         decode.caps_next = !caps_on;
      end else begin
         decode.has_char = raw_ch != '0;
      end
   end

endmodule

`default_nettype wire

// File: design/scancode_to_ascii_decoder_core.sv
// set-1 scancode to ascii decoder, top level
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_scancode[7:0]
//   rsp      out        rsp_valid/stall   rsp_ascii_char[6:0]
//
// one scancode per cycle sustained unless a result is held by rsp_stall; rsp valid follows the req transfer
// (the transfer loads the input register, the lookup then loads the result register)
// shift and caps flags update as an item leaves the input register
// a result waiting under rsp_stall holds back only items that yield a character
// reset is synchronous and clears the flags and both valid bits
`default_nettype none

module scancode_to_ascii_decoder_core import s2a_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_scancode,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_ascii_char
);

`include "assert_macros.svh"

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_code_ff;
   logic [7:0] in_code_in;
   logic       shift_held_ff;
   logic       shift_held_in;
   logic       caps_on_ff;
   logic       caps_on_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   char_type   rsp_char_ff;
   char_type   rsp_char_in;

   decode_type decode;
   logic       out_open;
   logic       advance;
   logic       req_take;

   s2a_keymap u_keymap (
      .scancode   (in_code_ff),
      .shift_held (shift_held_ff),
      .caps_on    (caps_on_ff),
      .decode     (decode)
   );

   assign out_open = !rsp_valid_ff || !rsp_stall;
   // items with no character never wait on the result side
   assign advance  = in_valid_ff && (!decode.has_char || out_open);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in   = req_take || (in_valid_ff && !advance);
      in_code_in    = req_take ? req_scancode : in_code_ff;
      shift_held_in = advance ? decode.shift_next : shift_held_ff;
      caps_on_in    = advance ? decode.caps_next : caps_on_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      if (out_open) begin
         rsp_valid_in = advance && decode.has_char;
         rsp_char_in  = decode.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         shift_held_ff <= 1'b0;
         caps_on_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         shift_held_ff <= shift_held_in;
         caps_on_ff    <= caps_on_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      in_code_ff  <= in_code_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;

   `ASSERT_SAME(a_rsp_nonzero, clock, reset, rsp_valid_ff, rsp_char_ff != '0, "rsp char is zero")
   `ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall, in_valid_ff, "stall with empty input register")
   `ASSERT_NEXT(a_caps_only_on_caps, clock, reset, advance && (in_code_ff[6:0] != SC_CAPS || in_code_ff[7]), caps_on_ff == $past(caps_on_ff), "caps changed by other code")
   `ASSERT_NEXT(a_flags_hold_idle, clock, reset, !advance, shift_held_ff == $past(shift_held_ff), "shift changed without transfer")

endmodule

`default_nettype wire

// File: tb/tb_scancode_to_ascii_decoder_core.sv
// self-checking testbench for the set-1 scancode to ascii decoder
`timescale 1ns / 1ps

module tb_scancode_to_ascii_decoder_core import s2a_pkg::*;;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int US_KEYS      = 58;

   localparam logic [7:0] PRESS_LSHIFT = {1'b0, SC_LSHIFT};
   localparam logic [7:0] PRESS_RSHIFT = {1'b0, SC_RSHIFT};
   localparam logic [7:0] PRESS_CAPS   = {1'b0, SC_CAPS};

   // us layout, unshifted and shifted
   localparam char_type US_PLAIN [0:US_KEYS-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20
   };

   localparam char_type US_SHIFTED [0:US_KEYS-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_scancode;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [6:0] rsp_ascii_char;

   logic       shift_down;
   logic       caps_engaged;
   char_type   expected_chars [$];
   char_type   oldest_char;
   bit         idle_on;
   int         stall_left;
   int         errors;
   int         cycles;
   int         sent_items;

   scancode_to_ascii_decoder_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_scancode   (req_scancode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic char_type key_char(input logic [6:0] key, input logic shifted);
      if (key >= US_KEYS)
         return '0;
      return shifted ? US_SHIFTED[key[5:0]] : US_PLAIN[key[5:0]];
   endfunction

   // keyboard state machine in step with every accepted scancode
   function automatic void decode_keystroke(input logic [7:0] sc);
      logic [6:0] key;
      char_type   ch;
      key = sc[6:0];
      if ((sc & RELEASE_BIT) != 8'h00) begin
         if (key == SC_LSHIFT || key == SC_RSHIFT) begin
            shift_down = 1'b0;
         end
      end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
         shift_down = 1'b1;
      end else if (key == SC_CAPS) begin
         caps_engaged = ~caps_engaged;
      end else if (key < TABLE_ENTRIES) begin
         ch = key_char(key, shift_down);
         if (ch != '0) begin
            if (caps_engaged != shift_down) begin
               if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
                  ch = ch - CASE_DELTA;
            end else begin
               if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
                  ch = ch + CASE_DELTA;
            end
            expected_chars.push_back(ch);
         end
      end
   endfunction

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 8);
      return $urandom_range(15, 50);
   endfunction

   // called and returns at a falling edge
   task automatic send_scancode(input logic [7:0] sc);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_scancode <= sc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_keystroke(sc);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic test_plain_keys();
      send_scancode(8'h02);
      send_scancode(8'h10);
      send_scancode(8'h0E);
      send_scancode(8'h0F);
      send_scancode(8'h1C);
      send_scancode(8'h39);
   endtask

   task automatic test_caps_lock();
      send_scancode(PRESS_CAPS);
      send_scancode(8'h1E);
      send_scancode(8'h0B);
      send_scancode(RELEASE_BIT | PRESS_CAPS);
      send_scancode(PRESS_CAPS);
      send_scancode(8'h1E);
   endtask

   task automatic test_shift_keys();
      send_scancode(PRESS_LSHIFT);
      send_scancode(8'h1E);
      // caps and shift together cancel for letters
      send_scancode(PRESS_CAPS);
      send_scancode(8'h1E);
      send_scancode(8'h02);
      send_scancode(RELEASE_BIT | PRESS_LSHIFT);
      send_scancode(PRESS_RSHIFT);
      send_scancode(8'h35);
      send_scancode(RELEASE_BIT | PRESS_RSHIFT);
   endtask

   task automatic test_ignored_codes();
      send_scancode(8'h00);
      send_scancode(8'h3B);
      send_scancode(8'h7F);
      send_scancode(8'hFF);
   endtask

   // typing bursts: key press and release, shifted words, caps toggles, noise
   task automatic test_random_typing(input int target);
      int         start;
      int         r;
      int         n;
      logic [7:0] k;
      logic [7:0] sh;
      start = sent_items;
      while (sent_items - start < target) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            k = 8'($urandom_range(0, US_KEYS - 1));
            send_scancode(k);
            if ($urandom_range(0, 9) < 8)
               send_scancode(k | RELEASE_BIT);
         end else if (r < 80) begin
            sh = $urandom_range(0, 1) ? PRESS_LSHIFT : PRESS_RSHIFT;
            send_scancode(sh);
            n = $urandom_range(1, 6);
            repeat (n) begin
               k = 8'($urandom_range(0, US_KEYS - 1));
               send_scancode(k);
               send_scancode(k | RELEASE_BIT);
            end
            // sometimes the other shift is released
            if ($urandom_range(0, 4) == 0)
               sh = (sh == PRESS_LSHIFT) ? PRESS_RSHIFT : PRESS_LSHIFT;
            send_scancode(sh | RELEASE_BIT);
         end else if (r < 86) begin
            send_scancode(PRESS_CAPS);
            send_scancode(PRESS_CAPS | RELEASE_BIT);
         end else begin
            send_scancode(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // receiver backpressure
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 99) < 20)
               stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_ascii_char);
            errors++;
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_ascii_char !== oldest_char) begin
               $display("%0t: ascii_char mismatch, expected %h, actual %h",
                        $time, oldest_char, rsp_ascii_char);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int n;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_scancode = 8'h00;
      rsp_stall    = 1'b0;
      shift_down   = 1'b0;
      caps_engaged = 1'b0;
      idle_on      = 1'b0;
      stall_left   = 0;
      errors       = 0;
      cycles       = 0;
      sent_items   = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_plain_keys();
      idle_on = 1'b1;
      test_caps_lock();
      test_shift_keys();
      test_ignored_codes();
      // back-to-back stretch, then with idling on both sides
      idle_on = 1'b0;
      test_random_typing(200);
      idle_on = 1'b1;
      test_random_typing(925);

      req_valid <= 1'b0;
      n = 0;
      while (expected_chars.size() > 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
      if (expected_chars.size() > 0) begin
         $display("%0t: %0d expected results never arrived, next expected %h",
                  $time, expected_chars.size(), expected_chars[0]);
         errors++;
      end
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
